// ===== hw/rtl/upc_pkg.sv =====
// shared types, constants and helper functions of the percent codec
package upc_pkg;

   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      MODE_FORM   = 2'd0,
      MODE_QUOTE  = 2'd1,
      MODE_DECODE = 2'd2,
      MODE_RAW    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_PERCENT = 2'd1,
      PHASE_HIGH    = 2'd2
   } phase_type;

   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharQuote   = 8'h22;
   localparam logic [7:0] CharApos    = 8'h27;
   localparam logic [7:0] CharStar    = 8'h2A;
   localparam logic [7:0] CharDash    = 8'h2D;
   localparam logic [7:0] CharUnder   = 8'h5F;
   localparam logic [7:0] CharDot     = 8'h2E;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
      logic       bad_escape;
   } rsp_type;

   // one unit of work for the back end: a single result or a three-byte escape
   typedef struct packed {
      logic       escape;
      logic [7:0] data;
      logic       err;
      logic       done;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'd0, n};
      end
      return 8'h57 + {4'd0, n};
   endfunction

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = c[3:0];
      if (c inside {[8'h30:8'h39]}) begin
         h.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic form_passes(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
             (c inside {CharSpace, CharStar, CharDash, CharUnder, CharDot});
   endfunction

endpackage

// ===== hw/rtl/upc_queue.sv =====
// small register queue of jobs between front and back end
module upc_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  upc_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output upc_pkg::job_type  head_data
);
   import upc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/upc_front.sv =====
// front end: mode register, decode escape tracking and job classification
module upc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   input  logic              accept,
   input  upc_pkg::req_type  req,
   output logic              job_valid,
   output upc_pkg::job_type  job
);
   import upc_pkg::*;

   mode_type   mode_ff;
   phase_type  phase_ff, phase_in;
   logic [3:0] high_ff, high_in;
   hex_type    hex;
   logic [7:0] c;
   logic       last;

   assign c    = req.in_byte;
   assign last = req.end_of_string;
   assign hex  = hex_value(c);

   // next escape state
   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      if (mode_ff == MODE_DECODE) begin
         case (phase_ff)
            PHASE_IDLE: begin
               if (c == CharPercent) begin
                  phase_in = PHASE_PERCENT;
               end
            end
            PHASE_PERCENT: begin
               if (hex.valid) begin
                  high_in  = hex.value;
                  phase_in = PHASE_HIGH;
               end else begin
                  phase_in = PHASE_IDLE;
               end
            end
            default: phase_in = PHASE_IDLE;
         endcase
         if (last) begin
            phase_in = PHASE_IDLE;
            high_in  = 4'd0;
         end
      end
   end

   // job produced by the current byte
   always_comb begin
      job_valid  = accept;
      job.escape = 1'b0;
      job.data   = c;
      job.err    = 1'b0;
      job.done   = last;
      case (mode_ff)
         MODE_FORM: begin
            if (c == CharSpace) begin
               job.data = CharPlus;
            end else if (!form_passes(c)) begin
               job.escape = 1'b1;
            end
         end
         MODE_QUOTE: begin
            if (c inside {CharPercent, CharQuote, CharApos}) begin
               job.escape = 1'b1;
            end
         end
         MODE_DECODE: begin
            case (phase_ff)
               PHASE_IDLE: begin
                  if (c == CharPlus) begin
                     job.data = CharSpace;
                  end else if (c == CharPercent) begin
                     job_valid = 1'b0;
                  end
               end
               PHASE_PERCENT: begin
                  if (hex.valid) begin
                     job_valid = 1'b0;
                  end else begin
                     job.err  = 1'b1;
                     job.data = 8'd0;
                  end
               end
               default: begin
                  if (hex.valid) begin
                     job.data = {high_ff, hex.value};
                  end else begin
                     job.err  = 1'b1;
                     job.data = 8'd0;
                  end
               end
            endcase
            // a string that ends inside an escape still reports
            if (accept && last && !job_valid) begin
               job_valid = 1'b1;
               job.err   = 1'b1;
               job.data  = 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FORM;
         phase_ff <= PHASE_IDLE;
         high_ff  <= 4'd0;
      end else if (csr_wr_en) begin
         mode_ff  <= mode_type'(csr_wr_data);
         phase_ff <= PHASE_IDLE;
         high_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
      end
   end

endmodule

// ===== hw/rtl/upc_back.sv =====
// back end: expands jobs into result bytes behind an output register
module upc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  upc_pkg::job_type  head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output upc_pkg::rsp_type  rsp_payload
);
   import upc_pkg::*;

   localparam logic [1:0] SlotPercent = 2'd0;
   localparam logic [1:0] SlotHigh    = 2'd1;
   localparam logic [1:0] SlotLow     = 2'd2;

   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load, fire, final_slot;

   assign load       = !rsp_valid_ff || rsp_ready;
   assign fire       = head_valid && load;
   assign final_slot = !head_data.escape || (slot_ff == SlotLow);
   assign pop        = fire && final_slot;

   always_comb begin
      rsp_in.out_byte    = head_data.data;
      rsp_in.last_of_run = final_slot;
      rsp_in.string_done = final_slot && head_data.done;
      rsp_in.bad_escape  = head_data.err;
      if (head_data.escape) begin
         case (slot_ff)
            SlotPercent: rsp_in.out_byte = CharPercent;
            SlotHigh:    rsp_in.out_byte = hex_digit(head_data.data[7:4]);
            default:     rsp_in.out_byte = hex_digit(head_data.data[3:0]);
         endcase
      end
      slot_in = slot_ff;
      if (fire) begin
         slot_in = final_slot ? SlotPercent : slot_ff + 2'd1;
      end
      rsp_valid_in = fire ? 1'b1 : (load ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SlotPercent;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/url_percent_codec.sv =====
// top level of the form-style percent escaping codec
// One byte enters per transfer on the req channel; zero to three result bytes
// leave on the rsp channel, one per transfer. Mode (csr, reset 0): 0 form
// encode, 1 quote escape, 2 decode, 3 pass-through; a mode write also clears
// the decode escape state. A byte that yields one result leaves as one byte,
// an escaped byte as three; the rsp port sends one byte per cycle while
// rsp_ready is high, and the front end keeps accepting bytes into a
// QUEUE_DEPTH-entry job queue while the back end drains. In decode mode a
// '%' and the first hex digit yield nothing; the result follows the second
// digit. Bad hex digits and strings ending mid-escape yield a result with
// bad_escape set and out_byte 0. last_of_run marks the last result of a
// byte, string_done the last result of a byte marked end_of_string.
module url_percent_codec #(
   parameter int QUEUE_DEPTH = upc_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   // input bytes
   input  logic              req_valid,
   output logic              req_ready,
   input  upc_pkg::req_type  req_payload,
   // result bytes
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output upc_pkg::rsp_type  rsp_payload
);
   import upc_pkg::*;

   logic    accept;
   logic    job_valid;
   job_type job;
   logic    queue_full;
   logic    head_valid;
   job_type head_data;
   logic    pop;

   // a byte is taken whenever the queue has room, even if it yields no job
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // front end: classify each byte and track decode escapes
   upc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_payload),
      .job_valid   (job_valid),
      .job         (job)
   );

   // decouples byte intake from result expansion
   upc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_data  (job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back end: one or three result bytes per job, registered output
   upc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/url_percent_codec_test.sv =====
// self-checking testbench for the url_percent_codec percent escaping codec
`timescale 1ns / 1ps

module url_percent_codec_test;
   import upc_pkg::*;

   // run limits
   localparam int CycleLimit   = 200000;
   localparam int SettleCycles = 12;   // a '%' or first digit leaves no result behind
   localparam int HoldCycles   = 80;   // long receiver hold-off, fills the job queue
   localparam int PhaseItems   = 34;
   localparam int MaxPrinted   = 40;

   // character codes the predictor needs beyond the package set
   localparam logic [7:0] DigitZero = 8'h30;
   localparam logic [7:0] DigitNine = 8'h39;
   localparam logic [7:0] UpperA    = 8'h41;
   localparam logic [7:0] UpperF    = 8'h46;
   localparam logic [7:0] UpperZ    = 8'h5A;
   localparam logic [7:0] LowerA    = 8'h61;
   localparam logic [7:0] LowerF    = 8'h66;
   localparam logic [7:0] LowerZ    = 8'h7A;
   localparam logic [7:0] ErrorByte = 8'h00;

   // idling profiles: none, sender idle, receiver stalling, both
   localparam int IdlePct [4]  = '{0, 72, 0, 37};
   localparam int StallPct [4] = '{0, 0, 72, 37};
   localparam mode_type PhaseModes [8] = '{MODE_FORM, MODE_DECODE, MODE_QUOTE, MODE_RAW,
                                           MODE_DECODE, MODE_FORM, MODE_DECODE, MODE_QUOTE};
   localparam logic [7:0] Specials [8] = '{CharSpace, CharStar, CharDash, CharUnder,
                                           CharDot, CharPercent, CharQuote, CharApos};

   // one row of the directed table; typed rows carry their single result
   typedef struct packed {
      logic       wr;        // write the mode (after draining) before this byte
      mode_type   mode;
      logic [7:0] in_byte;
      logic       eos;
      logic       typed;
      logic [7:0] t_byte;
      logic       t_bad;
   } stim_row_type;

   localparam int RowCount = 25;
   stim_row_type directed_rows [RowCount] = '{
      '{1'b1, MODE_FORM,   8'h61, 1'b0, 1'b1, 8'h61, 1'b0},  // letter passes
      '{1'b0, MODE_FORM,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0},  // zero byte, padded escape
      '{1'b0, MODE_FORM,   8'h20, 1'b0, 1'b1, 8'h2B, 1'b0},  // space to plus
      '{1'b0, MODE_FORM,   8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},  // top byte escaped, ends string
      '{1'b1, MODE_QUOTE,  8'h25, 1'b0, 1'b0, 8'h00, 1'b0},  // percent escaped
      '{1'b0, MODE_QUOTE,  8'h22, 1'b0, 1'b0, 8'h00, 1'b0},  // double quote escaped
      '{1'b0, MODE_QUOTE,  8'h27, 1'b1, 1'b0, 8'h00, 1'b0},  // apostrophe escaped, ends string
      '{1'b0, MODE_QUOTE,  8'h7A, 1'b1, 1'b1, 8'h7A, 1'b0},  // one-byte string
      '{1'b1, MODE_DECODE, 8'h2B, 1'b0, 1'b1, 8'h20, 1'b0},  // plus to space
      '{1'b0, MODE_DECODE, 8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h41, 1'b0, 1'b0, 8'h00, 1'b0},  // upper-case high digit
      '{1'b0, MODE_DECODE, 8'h66, 1'b0, 1'b1, 8'hAF, 1'b0},  // lower-case low digit
      '{1'b0, MODE_DECODE, 8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h67, 1'b0, 1'b1, ErrorByte, 1'b1},  // bad first digit
      '{1'b0, MODE_DECODE, 8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h78, 1'b0, 1'b1, ErrorByte, 1'b1},  // bad second digit
      '{1'b0, MODE_DECODE, 8'h25, 1'b1, 1'b1, ErrorByte, 1'b1},  // string ends on '%'
      '{1'b0, MODE_DECODE, 8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h37, 1'b1, 1'b1, ErrorByte, 1'b1},  // ends after one digit
      '{1'b0, MODE_DECODE, 8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_DECODE, 8'h34, 1'b0, 1'b0, 8'h00, 1'b0},  // left inside an escape
      '{1'b1, MODE_DECODE, 8'h31, 1'b1, 1'b1, 8'h31, 1'b0},  // mode write cleared the escape
      '{1'b1, MODE_RAW,    8'h80, 1'b1, 1'b1, 8'h80, 1'b0},  // unused mode passes bytes
      '{1'b0, MODE_RAW,    8'h25, 1'b0, 1'b1, 8'h25, 1'b0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = 2'd0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   url_percent_codec dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state, mirrors the block after reset
   mode_type   codec_mode = MODE_FORM;
   phase_type  esc_phase  = PHASE_IDLE;
   logic [3:0] hi_nib     = 4'd0;

   rsp_type fresh_rsp [$];    // results of the byte just predicted
   rsp_type pending_rsp [$];  // results still owed by the block, oldest first

   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MaxPrinted) begin
         $display("mismatch on %0s: got %0h expected %0h at cycle %0d",
                  what, got, want, cycle_count);
      end
      error_count++;
   endtask

   function automatic void add_result(input logic [7:0] b, input logic err);
      rsp_type r;
      r.out_byte    = b;
      r.last_of_run = 1'b0;
      r.string_done = 1'b0;
      r.bad_escape  = err;
      fresh_rsp.push_back(r);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return DigitZero + 8'(n);
      end
      return LowerA + 8'(n) - 8'd10;
   endfunction

   // '%' then two lower-case digits, always two
   function automatic void add_escape(input logic [7:0] c);
      add_result(CharPercent, 1'b0);
      add_result(hex_char(c[7:4]), 1'b0);
      add_result(hex_char(c[3:0]), 1'b0);
   endfunction

   // digit value, or -1 for anything that is not a hex digit
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= DigitZero && c <= DigitNine) return int'(c - DigitZero);
      if (c >= LowerA && c <= LowerF) return int'(c - LowerA) + 10;
      if (c >= UpperA && c <= UpperF) return int'(c - UpperA) + 10;
      return -1;
   endfunction

   // works out the results of one accepted byte into fresh_rsp
   function automatic void predict_codec_output(input req_type item);
      logic [7:0] c;
      logic       fin;
      int         v;
      c   = item.in_byte;
      fin = item.end_of_string;
      fresh_rsp.delete();
      case (codec_mode)
         MODE_FORM: begin
            if (c == CharSpace) begin
               add_result(CharPlus, 1'b0);
            end else if ((c >= DigitZero && c <= DigitNine) || (c >= UpperA && c <= UpperZ) ||
                         (c >= LowerA && c <= LowerZ) || c == CharStar || c == CharDash ||
                         c == CharUnder || c == CharDot) begin
               add_result(c, 1'b0);
            end else begin
               add_escape(c);
            end
         end
         MODE_QUOTE: begin
            if (c == CharPercent || c == CharQuote || c == CharApos) begin
               add_escape(c);
            end else begin
               add_result(c, 1'b0);
            end
         end
         MODE_DECODE: begin
            case (esc_phase)
               PHASE_IDLE: begin
                  if (c == CharPlus) begin
                     add_result(CharSpace, 1'b0);
                  end else if (c == CharPercent) begin
                     esc_phase = PHASE_PERCENT;
                  end else begin
                     add_result(c, 1'b0);
                  end
               end
               PHASE_PERCENT: begin
                  v = nibble_of(c);
                  if (v < 0) begin
                     add_result(ErrorByte, 1'b1);
                     esc_phase = PHASE_IDLE;
                  end else begin
                     hi_nib    = 4'(v);
                     esc_phase = PHASE_HIGH;
                  end
               end
               default: begin
                  v = nibble_of(c);
                  if (v < 0) begin
                     add_result(ErrorByte, 1'b1);
                  end else begin
                     add_result({hi_nib, 4'(v)}, 1'b0);
                  end
                  esc_phase = PHASE_IDLE;
               end
            endcase
            // a final byte always answers, and leaves the escape
            if (fin) begin
               if (fresh_rsp.size() == 0) begin
                  add_result(ErrorByte, 1'b1);
               end
               esc_phase = PHASE_IDLE;
               hi_nib    = 4'd0;
            end
         end
         default: begin
            add_result(c, 1'b0);
         end
      endcase
      if (fresh_rsp.size() > 0) begin
         fresh_rsp[fresh_rsp.size() - 1].last_of_run = 1'b1;
         fresh_rsp[fresh_rsp.size() - 1].string_done = fin;
      end
   endfunction

   // offers one byte, with a random gap first, and books its results on transfer
   task automatic send_item(input req_type item, input logic typed, input rsp_type typed_rsp);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_codec_output(item);
      if (typed) begin
         pending_rsp.push_back(typed_rsp);
      end else begin
         foreach (fresh_rsp[i]) pending_rsp.push_back(fresh_rsp[i]);
      end
      items_sent++;
   endtask

   // sender pauses until every owed result is back, then lets the block settle
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // mode writes only on an idle block; a write also clears the escape state
   task automatic set_mode(input mode_type m);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      codec_mode = m;
      esc_phase  = PHASE_IDLE;
      hi_nib     = 4'd0;
   endtask

   function automatic logic [7:0] random_hex_char();
      int n;
      n = $urandom_range(15);
      if (n < 10) return DigitZero + 8'(n);
      if ($urandom_range(1) == 1) return LowerA + 8'(n - 10);
      return UpperA + 8'(n - 10);
   endfunction

   // one random string; in decode mostly well-formed escapes, some noise and breakage
   task automatic send_random_string(input mode_type m);
      req_type text [$];
      req_type item;
      int      len;
      int      pick;
      int      i;
      item.end_of_string = 1'b0;
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (m == MODE_DECODE) begin
            if (pick < 50) begin
               item.in_byte = CharPercent;   text.push_back(item);
               item.in_byte = random_hex_char(); text.push_back(item);
               item.in_byte = random_hex_char(); text.push_back(item);
            end else if (pick < 65) begin
               item.in_byte = CharPlus;      text.push_back(item);
            end else if (pick < 85) begin
               item.in_byte = 8'($urandom_range(255)); text.push_back(item);
            end else if (pick < 93) begin
               // escape with a likely bad digit
               item.in_byte = CharPercent;   text.push_back(item);
               item.in_byte = 8'($urandom_range(255)); text.push_back(item);
            end else begin
               // escape cut short after one digit
               item.in_byte = CharPercent;   text.push_back(item);
               item.in_byte = random_hex_char(); text.push_back(item);
            end
         end else begin
            if (pick < 50) begin
               item.in_byte = 8'($urandom_range(255));
            end else if (pick < 75) begin
               item.in_byte = Specials[3'($urandom_range(7))];
            end else begin
               item.in_byte = 8'($urandom_range(8'h20, 8'h7E));
            end
            text.push_back(item);
         end
      end
      text[text.size() - 1].end_of_string = 1'b1;
      foreach (text[k]) send_item(text[k], 1'b0, '0);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HoldCycles;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // checker: every result transfer against the oldest owed result
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing owed", int'(rsp_payload), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_payload.out_byte), int'(want.out_byte));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", int'(rsp_payload.last_of_run),
                               int'(want.last_of_run));
            if (rsp_payload.string_done !== want.string_done)
               report_mismatch("string_done", int'(rsp_payload.string_done),
                               int'(want.string_done));
            if (rsp_payload.bad_escape !== want.bad_escape)
               report_mismatch("bad_escape", int'(rsp_payload.bad_escape),
                               int'(want.bad_escape));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("url_percent_codec regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      req_type   item;
      rsp_type   typed_rsp;
      int        k;
      int        p;
      int        start_count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: extremes, every mode, each decode corner
      for (k = 0; k < RowCount; k++) begin
         row = directed_rows[5'(k)];
         if (row.wr) set_mode(row.mode);
         item.in_byte          = row.in_byte;
         item.end_of_string    = row.eos;
         typed_rsp.out_byte    = row.t_byte;
         typed_rsp.last_of_run = 1'b1;
         typed_rsp.string_done = row.eos;
         typed_rsp.bad_escape  = row.t_bad;
         send_item(item, row.typed, typed_rsp);
      end

      // back-pressure: receiver holds off while random bytes, mostly escaped, keep arriving back to back
      set_mode(MODE_FORM);
      hold_requests <= hold_requests + 1;
      for (k = 0; k < 20; k++) begin
         item.in_byte       = 8'($urandom_range(255));
         item.end_of_string = (k == 19);
         send_item(item, 1'b0, '0);
      end
      wait_until_drained();
      for (k = 0; k < 4; k++) begin
         item.in_byte       = Specials[3'($urandom_range(7))];
         item.end_of_string = (k == 3);
         send_item(item, 1'b0, '0);
      end

      // random phases across modes and idling profiles
      for (p = 0; p < 8; p++) begin
         sender_idle_pct    = IdlePct[2'(p % 4)];
         receiver_stall_pct = StallPct[2'(p % 4)];
         set_mode(PhaseModes[3'(p)]);
         start_count = items_sent;
         while (items_sent - start_count < PhaseItems) send_random_string(PhaseModes[3'(p)]);
      end

      wait_until_drained();
      if (error_count == 0) begin
         $display("url_percent_codec regression: pass");
      end else begin
         $display("url_percent_codec regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/upc_pkg.sv
hw/rtl/upc_queue.sv
hw/rtl/upc_front.sv
hw/rtl/upc_back.sv
hw/rtl/url_percent_codec.sv
tb/url_percent_codec_test.sv
